// ===== hdl/kvp_pkg.sv =====
// ----------------------------------------------------------------------------
// kvp_pkg
// Shared constants, types and helper functions for the text request parser.
// ----------------------------------------------------------------------------
package kvp_pkg;

  localparam int MAX_TOKENS_DEFAULT        = 10;
  localparam int MAX_REQUEST_BYTES_DEFAULT = 2048;

  // Token limit; the token counter width below covers every legal limit.
  localparam int MAX_TOKENS = MAX_TOKENS_DEFAULT;

  localparam int KW_COUNT = 16;
  localparam int CMD_W    = 5;
  localparam int TOK_W    = 4;
  localparam int SPOS_W   = 4;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 5'd0;

  localparam logic [3:0] NP_MATCHED = 4'd7;
  localparam logic [3:0] NP_FAIL    = 4'd8;

  localparam logic [55:0] NOREPLY_TEXT = "noreply";

  localparam logic [71:0] KW_TEXT [KW_COUNT] = '{
    72'("get"), 72'("gets"), 72'("set"), 72'("add"), 72'("replace"), 72'("cas"),
    72'("append"), 72'("prepend"), 72'("delete"), 72'("incr"), 72'("decr"),
    72'("stats"), 72'({"flush", "_all"}), 72'("version"), 72'("quit"), 72'("verbosity")
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd4, 4'd3, 4'd3, 4'd7, 4'd3, 4'd6, 4'd7,
    4'd6, 4'd4, 4'd4, 4'd5, 4'd9, 4'd7, 4'd4, 4'd9
  };

  // One processed byte as seen by the command matcher. Positions saturate at 15.
  typedef struct packed {
    logic                  step;
    logic                  done;
    logic [7:0]            data;
    logic [SPOS_W-1:0]     pos;
    logic [SPOS_W-1:0]     pos_after;
  } kvp_step_t;

  function automatic logic is_white(input logic [7:0] b);
    return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] p);
    logic [71:0] text;
    logic [3:0]  len;
    logic [3:0]  idx;
    text = KW_TEXT[k];
    len  = KW_LEN[k];
    idx  = 4'(len - 4'd1 - p);
    if (p < len) begin
      return text[8*idx +: 8];
    end
    return 8'd0;
  endfunction

  function automatic logic [7:0] noreply_char(input logic [2:0] i);
    logic [2:0] idx;
    idx = 3'(3'd6 - i);
    return NOREPLY_TEXT[8*idx +: 8];
  endfunction

endpackage

// ===== hdl/kv_text_request_parser.sv =====
// ----------------------------------------------------------------------------
// kv_text_request_parser
// Parses one text cache request, one byte per transfer, into command code,
// token count, noreply flag and key position, reported on the final byte.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields (tdata from bit 0 up)                             tlast
// s_*      in   request_byte[7:0]                                        last_byte
// m_*      out  cmd_code[4:0], token_count[8:5], no_reply[9],
//               key_offset[20:10], key_length[32:21] (default widths)   -
//
// A byte is registered on acceptance and parsed when it advances out of that
// register; the final byte also loads the result register. A new byte is accepted
// every cycle, limited only by a held result.
// The result is registered and made valid when the final byte is parsed.
// A stalled result blocks only the next final byte; other bytes keep flowing.
// Reset is synchronous and returns all parse state to the start of a request.
// ----------------------------------------------------------------------------
module kv_text_request_parser #(
  parameter int MAX_REQUEST_BYTES = kvp_pkg::MAX_REQUEST_BYTES_DEFAULT,
  parameter int OFS_W = $clog2(MAX_REQUEST_BYTES),
  parameter int LEN_W = $clog2(MAX_REQUEST_BYTES + 1),
  parameter int OUT_W = ((10 + OFS_W + LEN_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // request_byte
  input  logic             s_tlast,   // last_byte
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // cmd_code, token_count, no_reply,
                                      // key_offset, key_length
);
  import kvp_pkg::*;

  localparam int F_CNT = CMD_W;
  localparam int F_NR  = F_CNT + TOK_W;
  localparam int F_OFS = F_NR + 1;
  localparam int F_LEN = F_OFS + OFS_W;
  localparam logic [LEN_W-1:0] MAX_POS = LEN_W'(MAX_REQUEST_BYTES);
  localparam logic [TOK_W-1:0] TOK_MAX = TOK_W'(MAX_TOKENS);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       adv;
  logic       in_range;

  logic [LEN_W-1:0] byte_position;
  logic [LEN_W-1:0] pos_after;
  logic             inside_token;
  logic             inside_token_next;
  logic [TOK_W-1:0] tokens_seen;
  logic [TOK_W-1:0] tokens_seen_next;
  logic [3:0]       noreply_progress;
  logic [3:0]       noreply_progress_next;
  logic             last_token_noreply;
  logic             last_token_noreply_next;
  logic [OFS_W-1:0] key_start;
  logic [OFS_W-1:0] key_start_next;
  logic [LEN_W-1:0] key_bytes;
  logic [LEN_W-1:0] key_bytes_next;

  logic             trailing;
  logic             reply;
  logic [TOK_W-1:0] count_out;
  logic [CMD_W-1:0] cmd_code;
  logic [OUT_W-1:0] result;
  kvp_step_t        step;

  assign adv      = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;
  assign in_range = byte_position < MAX_POS;
  assign pos_after = in_range ? LEN_W'(byte_position + 1'b1) : byte_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_comb begin
    step.step      = adv && in_range;
    step.done      = adv && in_last;
    step.data      = in_byte;
    step.pos       = (byte_position > LEN_W'(15)) ? 4'd15 : byte_position[SPOS_W-1:0];
    step.pos_after = (pos_after > LEN_W'(15)) ? 4'd15 : pos_after[SPOS_W-1:0];
  end

  kvp_cmd_match u_cmd_match (
    .clk      (clk),
    .rst      (rst),
    .step_in  (step),
    .cmd_code (cmd_code)
  );

  always_comb begin
    inside_token_next       = inside_token;
    tokens_seen_next        = tokens_seen;
    noreply_progress_next   = noreply_progress;
    last_token_noreply_next = last_token_noreply;
    key_start_next          = key_start;
    key_bytes_next          = key_bytes;
    if (in_range) begin
      if (is_white(in_byte)) begin
        if (inside_token) begin
          inside_token_next       = 1'b0;
          last_token_noreply_next = (noreply_progress == NP_MATCHED);
        end
      end else if (inside_token || (tokens_seen < TOK_MAX)) begin
        if (!inside_token) begin
          tokens_seen_next      = TOK_W'(tokens_seen + 1'b1);
          inside_token_next     = 1'b1;
          noreply_progress_next = 4'd0;
          if (tokens_seen_next == TOK_W'(2)) begin
            key_start_next = byte_position[OFS_W-1:0];
            key_bytes_next = '0;
          end
        end
        if ((noreply_progress_next < NP_MATCHED) &&
            (in_byte == noreply_char(noreply_progress_next[2:0]))) begin
          noreply_progress_next = 4'(noreply_progress_next + 1'b1);
        end else begin
          noreply_progress_next = NP_FAIL;
        end
        if (tokens_seen_next == TOK_W'(2)) begin
          key_bytes_next = LEN_W'(key_bytes_next + 1'b1);
        end
      end
    end
  end

  always_comb begin
    trailing  = inside_token_next ? (noreply_progress_next == NP_MATCHED)
                                  : last_token_noreply_next;
    reply     = (tokens_seen_next != '0) && (tokens_seen_next < TOK_MAX) && trailing;
    count_out = TOK_W'(tokens_seen_next - {{(TOK_W-1){1'b0}}, reply});
    result    = '0;
    result[CMD_W-1:0]        = cmd_code;
    result[F_CNT +: TOK_W]   = count_out;
    result[F_NR]             = reply;
    if (tokens_seen_next >= TOK_W'(2)) begin
      result[F_OFS +: OFS_W] = key_start_next;
      result[F_LEN +: LEN_W] = key_bytes_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (adv && in_last)) begin
      byte_position      <= '0;
      inside_token       <= 1'b0;
      tokens_seen        <= '0;
      noreply_progress   <= 4'd0;
      last_token_noreply <= 1'b0;
      key_start          <= '0;
      key_bytes          <= '0;
    end else if (adv) begin
      byte_position      <= pos_after;
      inside_token       <= inside_token_next;
      tokens_seen        <= tokens_seen_next;
      noreply_progress   <= noreply_progress_next;
      last_token_noreply <= last_token_noreply_next;
      key_start          <= key_start_next;
      key_bytes          <= key_bytes_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_last) begin
      m_tdata <= result;
    end
  end

  a_token_limit: assert property (@(posedge clk) disable iff (rst)
    tokens_seen <= TOK_MAX)
    else $error("token counter beyond limit");

  a_inside_counted: assert property (@(posedge clk) disable iff (rst)
    inside_token |-> (tokens_seen != '0))
    else $error("inside a token with no token counted");

  a_reply_below_limit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[F_NR]) |-> (m_tdata[F_CNT +: TOK_W] < TOK_W'(MAX_TOKENS - 1)))
    else $error("noreply reported at token limit");

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    (adv && in_last) |=> (tokens_seen == '0) && !inside_token && (byte_position == '0))
    else $error("parse state not cleared after request end");

  a_result_on_end: assert property (@(posedge clk) disable iff (rst)
    (adv && in_last) |=> m_tvalid)
    else $error("request end without result");

endmodule

// ===== hdl/kvp_cmd_match.sv =====
// ----------------------------------------------------------------------------
// kvp_cmd_match
// Parallel keyword comparators for the command word at the start of a request.
// ----------------------------------------------------------------------------
module kvp_cmd_match (
  input  logic                      clk,
  input  logic                      rst,
  input  kvp_pkg::kvp_step_t        step_in,
  output logic [kvp_pkg::CMD_W-1:0] cmd_code
);
  import kvp_pkg::*;

  logic [KW_COUNT-1:0] alive;
  logic [KW_COUNT-1:0] alive_next;
  logic [KW_COUNT-1:0] hit;
  logic [CMD_W-1:0]    found;
  logic [CMD_W-1:0]    found_next;
  logic                decided;
  logic                decided_next;

  always_comb begin
    alive_next   = alive;
    found_next   = found;
    hit          = '0;
    if (step_in.step) begin
      for (int k = 0; k < KW_COUNT; k++) begin
        if (alive[k]) begin
          if (step_in.pos < KW_LEN[k]) begin
            if (step_in.data != kw_char(4'(k), step_in.pos)) begin
              alive_next[k] = 1'b0;
            end
          end else if (step_in.pos == KW_LEN[k]) begin
            alive_next[k] = 1'b0;
            hit[k]        = is_white(step_in.data);
          end
        end
      end
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
        if (hit[k] && !decided) begin
          found_next = CMD_W'(k + 1);
        end
      end
    end
    decided_next = decided | (|hit);
  end

  always_comb begin
    cmd_code = found_next;
    if (!decided_next) begin
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
        if (alive_next[k] && (KW_LEN[k] == step_in.pos_after)) begin
          cmd_code = CMD_W'(k + 1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || step_in.done) begin
      alive   <= '1;
      found   <= CMD_UNKNOWN;
      decided <= 1'b0;
    end else if (step_in.step) begin
      alive   <= alive_next;
      found   <= found_next;
      decided <= decided_next;
    end
  end

  a_decided_has_code: assert property (@(posedge clk) disable iff (rst)
    decided |-> (found != CMD_UNKNOWN))
    else $error("command decided without a code");

  a_undecided_no_code: assert property (@(posedge clk) disable iff (rst)
    !decided |-> (found == CMD_UNKNOWN))
    else $error("command code set while undecided");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit))
    else $error("more than one keyword completed on one byte");

  a_clear_after_done: assert property (@(posedge clk) disable iff (rst)
    step_in.done |=> (alive == '1) && !decided)
    else $error("matcher state not cleared after request end");

endmodule
